>>> rtl/pcpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcpa_pkg;

  // Fixed field widths of the item channels and the configuration port.
  localparam int ADDR_W      = 34;
  localparam int CPU_FIELD_W = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;

  // Default sizing of the allocator.
  localparam int CPUS_DEF       = 8;
  localparam int MAX_PAGES_DEF  = 32768;
  localparam int PAGE_BYTES_DEF = 4096;

  // Configuration reset values.
  localparam logic [ADDR_W-1:0] LOWEST_RST = 34'h0_8000_0000;
  localparam logic [ADDR_W-1:0] TOP_RST    = 34'h0_8800_0000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 1'b1;

  // Operation codes of an input item.
  localparam logic OP_FREE  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic check;
    logic apply;
    logic pop;
  } pcpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_emit;
    logic pop_needed;
  } pcpa_sts_t;

endpackage

`default_nettype wire

>>> rtl/pcpa_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one allocate or free item.
interface pcpa_req_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [pcpa_pkg::CPU_FIELD_W-1:0] requester_cpu;
  logic [pcpa_pkg::ADDR_W-1:0]      phys_address;

  modport source (output valid, opcode, requester_cpu, phys_address, input ready);
  modport sink (input valid, opcode, requester_cpu, phys_address, output ready);
endinterface

// Response channel: one result item per request.
interface pcpa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [pcpa_pkg::STATUS_W-1:0]    status;
  logic [pcpa_pkg::ADDR_W-1:0]      page_address;
  logic [pcpa_pkg::CPU_FIELD_W-1:0] source_cpu;

  modport source (output valid, status, page_address, source_cpu, input ready);
  modport sink (input valid, status, page_address, source_cpu, output ready);
endinterface

`default_nettype wire

>>> rtl/pcpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module pcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/pcpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: accept, check, apply (emit result), and pop the link for an alloc that finds a page.
module pcpa_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pcpa_pkg::pcpa_sts_t sts_i,
  output pcpa_pkg::pcpa_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_POP   = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_APPLY;
      end
      S_APPLY: begin
        // Hold here while the previous result has not been taken.
        if (sts_i.can_emit) begin
          cmd_o.apply = 1'b1;
          state_d     = sts_i.pop_needed ? S_POP : S_IDLE;
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcpa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Datapath: configuration, list heads, link memory, checks and result register.
module pcpa_dp #(
  parameter int CPUS       = pcpa_pkg::CPUS_DEF,
  parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pcpa_pkg::pcpa_cmd_t                 cmd_i,
  output pcpa_pkg::pcpa_sts_t                      sts_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [pcpa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [pcpa_pkg::ADDR_W-1:0]         cfg_wdata_i,
  input  wire logic                                opcode_i,
  input  wire logic [pcpa_pkg::CPU_FIELD_W-1:0]    requester_cpu_i,
  input  wire logic [pcpa_pkg::ADDR_W-1:0]         phys_address_i,
  pcpa_rsp_if.source                               rsp_o
);

  localparam int ADDR_W = pcpa_pkg::ADDR_W;
  localparam int CPU_FW = pcpa_pkg::CPU_FIELD_W;
  localparam int CPU_W  = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int SLOT_W = $clog2(MAX_PAGES);
  localparam int LINK_W = SLOT_W + 1;
  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int PAGE_W = ADDR_W - OFF_W;
  localparam int BASE_W = ADDR_W + 1 - OFF_W;
  localparam int DIFF_W = BASE_W + 1;
  localparam logic [ADDR_W:0] PAGE_M1 = (ADDR_W + 1)'(PAGE_BYTES - 1);
  localparam logic [ADDR_W:0] RST_SUM = {1'b0, pcpa_pkg::LOWEST_RST} + PAGE_M1;
  localparam logic [BASE_W-1:0] RST_BASE = BASE_W'(RST_SUM >> OFF_W);
  localparam logic [DIFF_W:0] MAXP = (DIFF_W + 1)'(MAX_PAGES);

  // Configuration; the window base page is kept precomputed.
  logic [ADDR_W-1:0] lowest_q, top_q;
  logic [BASE_W-1:0] base_q;
  logic [ADDR_W:0]   cfg_sum;

  assign cfg_sum = {1'b0, cfg_wdata_i} + PAGE_M1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q <= pcpa_pkg::LOWEST_RST;
      top_q    <= pcpa_pkg::TOP_RST;
      base_q   <= RST_BASE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcpa_pkg::CFG_LOWEST: begin
          lowest_q <= cfg_wdata_i;
          base_q   <= BASE_W'(cfg_sum >> OFF_W);
        end
        pcpa_pkg::CFG_TOP: begin
          top_q <= cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Requester index reduced to the number of lists.
  logic [CPU_W-1:0] req_mod;

  always_comb begin
    req_mod = '0;
    for (int i = 0; i < 8; i++) begin
      if (requester_cpu_i == 3'(i)) begin
        req_mod = CPU_W'(i % CPUS);
      end
    end
  end

  // Captured item.
  logic              op_q;
  logic [CPU_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      req_q  <= req_mod;
      addr_q <= phys_address_i;
    end
  end

  // List heads: valid bits in reset flops, slots without reset.
  logic [CPUS-1:0]   head_valid_q;
  logic [SLOT_W-1:0] head_slot_q [CPUS];

  // Free checks: alignment, bounds and window slot.
  logic              aligned;
  logic [PAGE_W-1:0] page;
  logic [DIFF_W-1:0] diff;
  logic              in_window;

  assign aligned   = (addr_q[OFF_W-1:0] == '0);
  assign page      = addr_q[ADDR_W-1:OFF_W];
  assign diff      = DIFF_W'(page) - DIFF_W'(base_q);
  assign in_window = !diff[DIFF_W-1] && ({1'b0, diff} < MAXP);

  // Cyclic scan for the first non-empty list, starting at the requester.
  logic             found;
  logic [CPU_W-1:0] pick;

  always_comb begin
    logic [CPU_W:0] idx;
    found = 1'b0;
    pick  = '0;
    idx   = '0;
    for (int j = CPUS - 1; j >= 0; j--) begin
      idx = (CPU_W + 1)'(req_q) + (CPU_W + 1)'(j);
      if (idx >= (CPU_W + 1)'(CPUS)) begin
        idx = idx - (CPU_W + 1)'(CPUS);
      end
      if (head_valid_q[idx[CPU_W-1:0]]) begin
        found = 1'b1;
        pick  = idx[CPU_W-1:0];
      end
    end
  end

  // Check-stage results.
  logic              bounds_ok_q, slot_ok_q, found_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CPU_W-1:0]  sel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      bounds_ok_q <= aligned && (addr_q >= lowest_q) && (addr_q < top_q);
      slot_ok_q   <= in_window;
      slot_q      <= diff[SLOT_W-1:0];
      found_q     <= found;
      sel_q       <= (op_q == pcpa_pkg::OP_ALLOC) ? pick : req_q;
    end
  end

  // Apply stage: push on a good free, start the link read on an alloc that found a page.
  logic              is_alloc, free_ok, ram_we, ram_re;
  logic [SLOT_W-1:0] sel_slot;
  logic [LINK_W-1:0] sel_link, ram_rdata;
  logic [BASE_W-1:0] alloc_page;

  assign is_alloc   = (op_q == pcpa_pkg::OP_ALLOC);
  assign free_ok    = bounds_ok_q && slot_ok_q;
  assign sel_slot   = head_slot_q[sel_q];
  assign sel_link   = {head_valid_q[sel_q], sel_slot};
  assign ram_we     = cmd_i.apply && !is_alloc && free_ok;
  assign ram_re     = cmd_i.apply && is_alloc && found_q;
  assign alloc_page = base_q + BASE_W'(sel_slot);

  pcpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_PAGES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (sel_link),
    .re_i    (ram_re),
    .raddr_i (sel_slot),
    .rdata_o (ram_rdata)
  );

  // Head valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= '0;
    end else if (ram_we) begin
      head_valid_q[sel_q] <= 1'b1;
    end else if (cmd_i.pop) begin
      head_valid_q[sel_q] <= ram_rdata[SLOT_W];
    end
  end

  // Head slots.
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      head_slot_q[sel_q] <= slot_q;
    end else if (cmd_i.pop) begin
      head_slot_q[sel_q] <= ram_rdata[SLOT_W-1:0];
    end
  end

  // Result register.
  logic                             out_valid_q;
  logic [pcpa_pkg::STATUS_W-1:0]    status_q;
  logic [ADDR_W-1:0]                page_addr_q;
  logic [CPU_FW-1:0]                src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.apply) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      if (is_alloc) begin
        status_q    <= found_q ? pcpa_pkg::STATUS_DONE : pcpa_pkg::STATUS_NO_PAGE;
        page_addr_q <= found_q ? {alloc_page[PAGE_W-1:0], {OFF_W{1'b0}}} : '0;
        src_q       <= found_q ? CPU_FW'(sel_q) : '0;
      end else begin
        status_q    <= free_ok ? pcpa_pkg::STATUS_DONE : pcpa_pkg::STATUS_BAD_ADDR;
        page_addr_q <= '0;
        src_q       <= '0;
      end
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.page_address = page_addr_q;
  assign rsp_o.source_cpu   = src_q;

  assign sts_o.can_emit   = !out_valid_q || rsp_o.ready;
  assign sts_o.pop_needed = is_alloc && found_q;

  // A successful free leaves its list non-empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> head_valid_q[sel_q])
    else $error("list empty after a successful free");

  // Out of memory is reported only when every list is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && is_alloc && !found_q) |-> (head_valid_q == '0))
    else $error("out of memory reported with a non-empty list");

  // A head update from the link memory follows a link read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> $past(ram_re))
    else $error("head popped without a link read");

  // A result appears only after an apply step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.apply))
    else $error("result valid without an apply step");

endmodule

`default_nettype wire

>>> rtl/per_cpu_page_allocator_top.sv
// A result is registered after its item passes the capture and check-stage registers.
// A new item is taken only in the idle step, after the last one is done;
// an alloc that finds a page also needs a pop step that writes the popped link word
// back into the list head register. A waiting result holds the block in its apply step.
// Reset (rst_ni, asynchronous, active low) empties all lists at once and
// loads the bound registers with their defaults; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module per_cpu_page_allocator_top #(
  parameter int CPUS       = pcpa_pkg::CPUS_DEF,
  parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pcpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pcpa_pkg::ADDR_W-1:0]    cfg_wdata_i,
  pcpa_req_if.sink                            req_i,
  pcpa_rsp_if.source                          rsp_o
);

  pcpa_pkg::pcpa_cmd_t cmd;
  pcpa_pkg::pcpa_sts_t sts;

  // Sequencer.
  pcpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath with heads, link memory and result register.
  pcpa_dp #(
    .CPUS       (CPUS),
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (req_i.opcode),
    .requester_cpu_i (req_i.requester_cpu),
    .phys_address_i  (req_i.phys_address),
    .rsp_o           (rsp_o)
  );

endmodule

`default_nettype wire
